// File: rtl/core/igc_pkg.sv
// shared types and constants for the interference graph coloring block
// no dependencies
package igc_pkg;

   localparam int MAX_STATIONS = 32;
   localparam int IDX_W        = $clog2(MAX_STATIONS);
   localparam int CNT_W        = $clog2(MAX_STATIONS + 1);
   localparam int COORD_W      = 16;
   localparam int RAD_W        = 15;
   localparam int OPND_W       = 16;
   localparam int SQ_W         = 2 * OPND_W;
   localparam int ACC_W        = SQ_W + 1;
   localparam int OUT_IDX_W    = 5;
   localparam int OUT_CNT_W    = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SQX,
      ST_SQY,
      ST_SQR,
      ST_CMP,
      ST_WRITE,
      ST_PREP,
      ST_COLOR,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic       sq_en;
      acc_op_type acc_op;
   } sqr_ctrl_type;

endpackage

// File: rtl/core/interference_graph_greedy_coloring_top.sv
// top level of the interference graph greedy coloring block
// depends on igc_pkg, igc_sqr_unit, igc_station_store
//
// stations (x, y, radius) come in one word per start pulse. each new station is
// tested against every stored one by a single shared squaring unit, in the steps
// memory read, dx squared, dy squared, radius sum squared and compare for each
// stored station, then a write step; busy stays high throughout. the word flagged
// last_station then triggers a setup step and greedy coloring, one station per
// cycle and one pass over the stored stations per color, after which one result
// word per station is strobed on consecutive cycles with rsp_strobe. the
// receiver cannot stall: every result is valid for exactly one cycle. stations
// beyond capacity are dropped and reported through rsp_overflow. the adjacency
// store is cleared at once after the batch, so there is no clearing pass after
// reset.
module interference_graph_greedy_coloring_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [igc_pkg::COORD_W-1:0]   req_x_pos,
   input  logic signed [igc_pkg::COORD_W-1:0]   req_y_pos,
   input  logic [igc_pkg::RAD_W-1:0]            req_radius,
   input  logic                                 req_last_station,
   output logic                                 rsp_strobe,
   output logic [igc_pkg::OUT_IDX_W-1:0]        rsp_station_index,
   output logic [igc_pkg::OUT_IDX_W-1:0]        rsp_color,
   output logic [igc_pkg::OUT_CNT_W-1:0]        rsp_color_count,
   output logic                                 rsp_overflow,
   output logic                                 rsp_last_result
);
   import igc_pkg::*;

   // sequencer
   state_type state_ff, state_in;

   // latched input word
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [RAD_W-1:0]          r_ff;
   logic                      last_ff;

   // batch bookkeeping
   logic [CNT_W-1:0]        count_ff;
   logic                    overflow_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [MAX_STATIONS-1:0] new_row_ff;
   logic [MAX_STATIONS-1:0] adj_ff [MAX_STATIONS];

   // coloring state
   logic [MAX_STATIONS-1:0] uncol_ff, hold_ff;
   logic [CNT_W-1:0]        round_ff, ncolors_ff;
   logic [IDX_W-1:0]        vcolor_ff [MAX_STATIONS];

   // result word registers
   logic                 rsp_strobe_ff;
   logic [OUT_IDX_W-1:0] rsp_index_ff, rsp_color_ff;
   logic [OUT_CNT_W-1:0] rsp_count_ff;
   logic                 rsp_overflow_ff, rsp_last_ff;

   // datapath controls from the sequencer
   sqr_ctrl_type      sqr_ctrl;
   logic              mem_rd_en, mem_wr_en;
   logic [OPND_W-1:0] operand;
   logic              hit;

   logic signed [COORD_W-1:0] mem_x, mem_y;
   logic [RAD_W-1:0]          mem_r;

   logic                  accept;
   logic                  store_full;
   logic                  last_idx;
   logic [IDX_W-1:0]      new_slot;
   logic signed [COORD_W:0] dx_diff, dy_diff;
   logic [OPND_W-1:0]     dx_abs, dy_abs, rad_sum;
   logic                  cand;
   logic [MAX_STATIONS-1:0] uncol_next;

   assign accept     = start && (state_ff == ST_IDLE);
   assign store_full = (count_ff == CNT_W'(MAX_STATIONS));
   assign last_idx   = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign new_slot   = count_ff[IDX_W-1:0];

   // absolute coordinate differences and radius sum
   assign dx_diff = {mem_x[COORD_W-1], mem_x} - {x_ff[COORD_W-1], x_ff};
   assign dy_diff = {mem_y[COORD_W-1], mem_y} - {y_ff[COORD_W-1], y_ff};
   assign dx_abs  = dx_diff[COORD_W] ? OPND_W'(-dx_diff) : OPND_W'(dx_diff);
   assign dy_abs  = dy_diff[COORD_W] ? OPND_W'(-dy_diff) : OPND_W'(dy_diff);
   assign rad_sum = OPND_W'(mem_r) + OPND_W'(r_ff);

   // greedy step: station idx takes the round color if no neighbor holds it
   assign cand       = uncol_ff[idx_ff] && ((adj_ff[idx_ff] & hold_ff) == '0);
   assign uncol_next = uncol_ff & ~(MAX_STATIONS'(cand) << idx_ff);

   igc_station_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (new_slot),
      .wr_x    (x_ff),
      .wr_y    (y_ff),
      .wr_r    (r_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_x    (mem_x),
      .rd_y    (mem_y),
      .rd_r    (mem_r)
   );

   igc_sqr_unit u_sqr (
      .clock   (clock),
      .ctrl    (sqr_ctrl),
      .operand (operand),
      .hit     (hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (store_full) begin
                  state_in = req_last_station ? ST_PREP : ST_IDLE;
               end else if (count_ff == '0) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ:  state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_SQR;
         ST_SQR:   state_in = ST_CMP;
         ST_CMP:   state_in = last_idx ? ST_WRITE : ST_READ;
         ST_WRITE: state_in = last_ff ? ST_PREP : ST_IDLE;
         ST_PREP:  state_in = (count_ff == '0) ? ST_IDLE : ST_COLOR;
         ST_COLOR: begin
            if (last_idx && (uncol_next == '0)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT:  state_in = last_idx ? ST_IDLE : ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      sqr_ctrl.sq_en  = 1'b0;
      sqr_ctrl.acc_op = ACC_HOLD;
      mem_rd_en       = 1'b0;
      mem_wr_en       = 1'b0;
      operand         = dx_abs;
      case (state_ff)
         ST_READ: mem_rd_en = 1'b1;
         ST_SQX: begin
            sqr_ctrl.sq_en = 1'b1;
            operand        = dx_abs;
         end
         ST_SQY: begin
            sqr_ctrl.sq_en  = 1'b1;
            sqr_ctrl.acc_op = ACC_LOAD;
            operand         = dy_abs;
         end
         ST_SQR: begin
            sqr_ctrl.sq_en  = 1'b1;
            sqr_ctrl.acc_op = ACC_ADD;
            operand         = rad_sum;
         end
         ST_WRITE: mem_wr_en = 1'b1;
         default: begin
            sqr_ctrl.sq_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state: count, overflow, adjacency
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         for (int j = 0; j < MAX_STATIONS; j++) begin
            adj_ff[j] <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start && store_full) begin
                  overflow_ff <= 1'b1;
               end
            end
            ST_CMP: begin
               if (hit) begin
                  adj_ff[idx_ff][new_slot] <= 1'b1;
               end
            end
            ST_WRITE: begin
               adj_ff[new_slot] <= new_row_ff;
               count_ff         <= count_ff + CNT_W'(1);
            end
            ST_PREP: begin
               if (count_ff == '0) begin
                  overflow_ff <= 1'b0;
               end
            end
            ST_EMIT: begin
               // batch done, clear for the next one
               if (last_idx) begin
                  count_ff    <= '0;
                  overflow_ff <= 1'b0;
                  for (int j = 0; j < MAX_STATIONS; j++) begin
                     adj_ff[j] <= '0;
                  end
               end
            end
            default: begin
               count_ff <= count_ff;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_ff       <= req_x_pos;
               y_ff       <= req_y_pos;
               r_ff       <= req_radius;
               last_ff    <= req_last_station;
               idx_ff     <= '0;
               new_row_ff <= '0;
            end
         end
         ST_CMP: begin
            if (hit) begin
               new_row_ff[idx_ff] <= 1'b1;
            end
            if (!last_idx) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
         ST_PREP: begin
            for (int j = 0; j < MAX_STATIONS; j++) begin
               uncol_ff[j] <= (CNT_W'(j) < count_ff);
            end
            hold_ff  <= '0;
            round_ff <= '0;
            idx_ff   <= '0;
         end
         ST_COLOR: begin
            if (cand) begin
               vcolor_ff[idx_ff] <= IDX_W'(round_ff);
            end
            uncol_ff <= uncol_next;
            if (last_idx) begin
               // end of a round
               idx_ff <= '0;
               if (uncol_next == '0) begin
                  ncolors_ff <= round_ff + CNT_W'(1);
               end else begin
                  round_ff <= round_ff + CNT_W'(1);
                  hold_ff  <= '0;
               end
            end else begin
               idx_ff <= idx_ff + IDX_W'(1);
               if (cand) begin
                  hold_ff[idx_ff] <= 1'b1;
               end
            end
         end
         ST_EMIT: begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   // result word, one per cycle while emitting
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT) begin
         rsp_index_ff    <= OUT_IDX_W'(idx_ff);
         rsp_color_ff    <= OUT_IDX_W'(vcolor_ff[idx_ff]);
         rsp_count_ff    <= OUT_CNT_W'(ncolors_ff);
         rsp_overflow_ff <= overflow_ff;
         rsp_last_ff     <= last_idx;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_station_index = rsp_index_ff;
   assign rsp_color         = rsp_color_ff;
   assign rsp_color_count   = rsp_count_ff;
   assign rsp_overflow      = rsp_overflow_ff;
   assign rsp_last_result   = rsp_last_ff;

endmodule

// File: rtl/core/igc_sqr_unit.sv
// shared square, accumulate and compare unit for the interference test
// depends on igc_pkg
module igc_sqr_unit (
   input  logic                       clock,
   input  igc_pkg::sqr_ctrl_type      ctrl,
   input  logic [igc_pkg::OPND_W-1:0] operand,
   output logic                       hit
);
   import igc_pkg::*;

   logic [SQ_W-1:0]  sq_ff;
   logic [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.sq_en) begin
         sq_ff <= SQ_W'(operand) * SQ_W'(operand);
      end
      case (ctrl.acc_op)
         ACC_LOAD: acc_ff <= ACC_W'(sq_ff);
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(sq_ff);
         default:  acc_ff <= acc_ff;
      endcase
   end

   // distance squared against squared radius sum
   assign hit = (acc_ff <= ACC_W'(sq_ff));

endmodule

// File: rtl/core/igc_station_store.sv
// station coordinate and radius memory, one write and one registered read port
// depends on igc_pkg
module igc_station_store (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [igc_pkg::IDX_W-1:0]          wr_addr,
   input  logic signed [igc_pkg::COORD_W-1:0] wr_x,
   input  logic signed [igc_pkg::COORD_W-1:0] wr_y,
   input  logic [igc_pkg::RAD_W-1:0]          wr_r,
   input  logic                               rd_en,
   input  logic [igc_pkg::IDX_W-1:0]          rd_addr,
   output logic signed [igc_pkg::COORD_W-1:0] rd_x,
   output logic signed [igc_pkg::COORD_W-1:0] rd_y,
   output logic [igc_pkg::RAD_W-1:0]          rd_r
);
   import igc_pkg::*;

   logic signed [COORD_W-1:0] x_mem [MAX_STATIONS];
   logic signed [COORD_W-1:0] y_mem [MAX_STATIONS];
   logic [RAD_W-1:0]          r_mem [MAX_STATIONS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         y_mem[wr_addr] <= wr_y;
         r_mem[wr_addr] <= wr_r;
      end
      if (rd_en) begin
         rd_x <= x_mem[rd_addr];
         rd_y <= y_mem[rd_addr];
         rd_r <= r_mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/igc_checker.sv
// port-level checks for the interference graph coloring top level
// no dependencies; bound to interference_graph_greedy_coloring_top
module igc_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [4:0] rsp_station_index,
   input logic [4:0] rsp_color,
   input logic [5:0] rsp_color_count,
   input logic       rsp_last_result
);

   // a color is always below the number of colors used
   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_color} < rsp_color_count))
      else $error("color not below color count");

   // result words of a batch come back to back in index order
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_result |=>
         rsp_strobe && (rsp_station_index == 5'($past(rsp_station_index) + 5'd1)))
      else $error("result words not consecutive");

   // a batch starts with station zero
   a_first_index: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe) |-> (rsp_station_index == 5'd0))
      else $error("batch does not start at index zero");

   // the block stays busy until the last word of a batch is out
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_result |-> busy)
      else $error("not busy while results remain");

   // a batch ends with the last word and nothing directly after it
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_result |=> !rsp_strobe)
      else $error("result word after last result");

endmodule

bind interference_graph_greedy_coloring_top igc_checker u_igc_checker (.*);

// File: tb/sv/tb.sv
// self-checking testbench for interference_graph_greedy_coloring_top
// depends on igc_pkg and the rtl under rtl/core; reads no files
//
// stations are sent through the start/busy command port, a local predictor
// builds the interference graph and colors each batch, and every strobed
// result word is compared field by field against the oldest predicted word
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import igc_pkg::*;

   // generous ceiling: worst batches, worst gaps and coloring, many times over
   localparam int CYCLE_LIMIT  = 1_000_000;
   // quiet cycles after the last predicted word, to catch stray strobes
   localparam int SETTLE_TICKS = 64;
   // percent of words preceded by a sender gap
   localparam int GAP_PERCENT  = 18;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [RAD_W-1:0]          radius_type;

   // one predicted result word
   typedef struct {
      logic [OUT_IDX_W-1:0] station_index;
      logic [OUT_IDX_W-1:0] color;
      logic [OUT_CNT_W-1:0] color_count;
      logic                 overflow;
      logic                 last_result;
   } color_word_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   coord_type            req_x_pos;
   coord_type            req_y_pos;
   radius_type           req_radius;
   logic                 req_last_station;
   logic                 rsp_strobe;
   logic [OUT_IDX_W-1:0] rsp_station_index;
   logic [OUT_IDX_W-1:0] rsp_color;
   logic [OUT_CNT_W-1:0] rsp_color_count;
   logic                 rsp_overflow;
   logic                 rsp_last_result;

   // predictor copy of the station store and the interference graph
   coord_type               known_x [MAX_STATIONS];
   coord_type               known_y [MAX_STATIONS];
   radius_type              known_radius [MAX_STATIONS];
   logic [MAX_STATIONS-1:0] neighbor_rows [MAX_STATIONS];
   int                      stored_count;
   bit                      dropped_station;

   color_word_type expected_colors[$];
   color_word_type due_word;
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             sender_pauses;

   interference_graph_greedy_coloring_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_x_pos         (req_x_pos),
      .req_y_pos         (req_y_pos),
      .req_radius        (req_radius),
      .req_last_station  (req_last_station),
      .rsp_strobe        (rsp_strobe),
      .rsp_station_index (rsp_station_index),
      .rsp_color         (rsp_color),
      .rsp_color_count   (rsp_color_count),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_result   (rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // exact integer test: squared distance against squared radius sum
   function automatic bit stations_interfere(int idx, coord_type x, coord_type y,
                                             radius_type r);
      longint dx;
      longint dy;
      longint reach;
      dx = longint'(known_x[idx]) - longint'(x);
      dy = longint'(known_y[idx]) - longint'(y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      reach = longint'(known_radius[idx]) + longint'(r);
      return (dx * dx + dy * dy) <= (reach * reach);
   endfunction

   // store one accepted station; on the last one color the batch, queue its
   // result words and clear the batch
   function automatic void predict_station(coord_type x, coord_type y, radius_type r,
                                           bit last);
      int                      k;
      int                      n;
      int                      round_color;
      int                      vertex_color [MAX_STATIONS];
      logic [MAX_STATIONS-1:0] uncolored;
      logic [MAX_STATIONS-1:0] holding;
      color_word_type          w;
      if (stored_count < MAX_STATIONS) begin
         k = stored_count;
         neighbor_rows[k] = '0;
         for (int i = 0; i < k; i++) begin
            if (stations_interfere(i, x, y, r)) begin
               neighbor_rows[i][k] = 1'b1;
               neighbor_rows[k][i] = 1'b1;
            end
         end
         known_x[k]      = x;
         known_y[k]      = y;
         known_radius[k] = r;
         stored_count    = k + 1;
      end else begin
         dropped_station = 1'b1;
      end
      if (!last) return;

      n = stored_count;
      uncolored = '0;
      for (int i = 0; i < n; i++) uncolored[i] = 1'b1;
      round_color = 0;
      // one round per color, stations in index order
      while (uncolored != '0) begin
         holding = '0;
         for (int i = 0; i < n; i++) begin
            if (uncolored[i] && (neighbor_rows[i] & holding) == '0) begin
               vertex_color[i] = round_color;
               holding[i]      = 1'b1;
               uncolored[i]    = 1'b0;
            end
         end
         round_color++;
      end
      for (int i = 0; i < n; i++) begin
         w.station_index = OUT_IDX_W'(i);
         w.color         = OUT_IDX_W'(vertex_color[i]);
         w.color_count   = OUT_CNT_W'(round_color);
         w.overflow      = dropped_station;
         w.last_result   = (i == n - 1);
         expected_colors.push_back(w);
      end
      for (int i = 0; i < MAX_STATIONS; i++) neighbor_rows[i] = '0;
      stored_count    = 0;
      dropped_station = 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // result checker: the receiver cannot stall, so every strobe is a word
   // ---------------------------------------------------------------------

   function automatic void check_field(string name, int due, int seen);
      if (due != seen) begin
         $error("%s: expected %0d, actual %0d", name, due, seen);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_colors.size() == 0) begin
            $error("station_index: expected no word, actual %0d", rsp_station_index);
            mismatch_count++;
         end else begin
            due_word = expected_colors.pop_front();
            check_field("station_index", int'(due_word.station_index),
                        int'(rsp_station_index));
            check_field("color", int'(due_word.color), int'(rsp_color));
            check_field("color_count", int'(due_word.color_count), int'(rsp_color_count));
            check_field("overflow", int'(due_word.overflow), int'(rsp_overflow));
            check_field("last_result", int'(due_word.last_result), int'(rsp_last_result));
         end
      end
   end

   // run ceiling
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("interference_graph_greedy_coloring_top: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   // send one station word; entered and left on a rising edge. start is left
   // high after acceptance so back-to-back words need no extra assignment
   task automatic send_station(coord_type x, coord_type y, radius_type r, bit last);
      int gap;
      if (sender_pauses && $urandom_range(99) < GAP_PERCENT) begin
         // mostly short gaps, now and then a long one
         gap = ($urandom_range(9) == 0) ? int'($urandom_range(20, 200)) :
                                          int'($urandom_range(1, 8));
         start            <= 1'b0;
         req_x_pos        <= coord_type'($urandom());
         req_y_pos        <= coord_type'($urandom());
         req_radius       <= radius_type'($urandom());
         req_last_station <= 1'($urandom_range(1));
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_x_pos        <= x;
      req_y_pos        <= y;
      req_radius       <= r;
      req_last_station <= last;
      do @(posedge clock); while (busy);
      predict_station(x, y, r, last);
   endtask

   // lower start and wait for every predicted word, then a quiet stretch
   task automatic drain_results();
      start <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // single-station batches at the coordinate and radius extremes
   task automatic test_lone_station();
      send_station(-16'sd32768, 16'sd32767, 15'd32767, 1'b1);
      send_station(16'sd32767, -16'sd32768, 15'd0, 1'b1);
   endtask

   // squared distance exactly equal to, and just above, the squared reach;
   // coincident stations of radius zero still interfere
   task automatic test_distance_boundary();
      send_station(16'sd0, 16'sd0, 15'd2, 1'b0);
      send_station(16'sd3, 16'sd4, 15'd3, 1'b0);
      send_station(-16'sd3, -16'sd4, 15'd2, 1'b0);
      send_station(16'sd0, 16'sd0, 15'd0, 1'b0);
      send_station(16'sd0, 16'sd0, 15'd0, 1'b1);
   endtask

   // corners with full radius miss each other, a center station hits them all
   task automatic test_far_corners();
      send_station(-16'sd32768, -16'sd32768, 15'd32767, 1'b0);
      send_station(16'sd32767, 16'sd32767, 15'd32767, 1'b0);
      send_station(-16'sd32768, 16'sd32767, 15'd32767, 1'b0);
      send_station(16'sd32767, -16'sd32768, 15'd32767, 1'b0);
      send_station(16'sd0, 16'sd0, 15'd32767, 1'b1);
   endtask

   // stacked stations: complete graph, one color each
   task automatic test_stacked_cluster();
      coord_type cx;
      coord_type cy;
      cx = coord_type'($urandom());
      cy = coord_type'($urandom());
      for (int i = 0; i < 6; i++) send_station(cx, cy, radius_type'($urandom()), i == 5);
   endtask

   // fill the store with a complete graph, then drop two more stations, the
   // second one carrying last; then a batch that fills the store exactly
   task automatic test_store_full();
      int cx;
      int cy;
      cx = $urandom_range(0, 60000) - 30000;
      cy = $urandom_range(0, 60000) - 30000;
      for (int i = 0; i < MAX_STATIONS + 2; i++) begin
         send_station(coord_type'(cx + $urandom_range(0, 3)),
                      coord_type'(cy + $urandom_range(0, 3)),
                      radius_type'(100 + $urandom_range(0, 50)), i == MAX_STATIONS + 1);
      end
      for (int i = 0; i < MAX_STATIONS; i++) begin
         send_station(coord_type'($urandom()), coord_type'($urandom()),
                      radius_type'($urandom()), i == MAX_STATIONS - 1);
      end
   endtask

   // random batches: mostly small, a few that come close to, fill or overrun the store;
   // stations scattered, clustered or both, so graphs range from empty to dense
   task automatic test_random_batches(int word_total);
      int         sent;
      int         batch_size;
      int         layout;
      int         center_x;
      int         center_y;
      int         spread;
      coord_type  x;
      coord_type  y;
      radius_type r;
      sent = 0;
      while (sent < word_total) begin
         batch_size = ($urandom_range(99) < 8) ?
                      int'($urandom_range(MAX_STATIONS - 2, MAX_STATIONS + 3)) :
                      int'($urandom_range(1, 8));
         layout   = int'($urandom_range(2));
         center_x = $urandom_range(0, 65535) - 32768;
         center_y = $urandom_range(0, 65535) - 32768;
         spread   = 1 << $urandom_range(1, 14);
         for (int i = 0; i < batch_size; i++) begin
            // a long stretch of back-to-back words in the middle
            sender_pauses = !(sent >= 30 && sent < 80);
            if (layout == 0 || (layout == 2 && $urandom_range(1) == 0) ||
                $urandom_range(19) == 0) begin
               x = coord_type'($urandom());
               y = coord_type'($urandom());
               r = radius_type'($urandom());
            end else begin
               x = coord_type'(center_x + int'($urandom_range(0, spread)) - spread / 2);
               y = coord_type'(center_y + int'($urandom_range(0, spread)) - spread / 2);
               r = radius_type'($urandom_range(0, spread));
            end
            send_station(x, y, r, i == batch_size - 1);
            sent++;
         end
      end
      sender_pauses = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_x_pos        <= '0;
      req_y_pos        <= '0;
      req_radius       <= '0;
      req_last_station <= 1'b0;
      sender_pauses    = 1'b1;
      stored_count     = 0;
      dropped_station  = 1'b0;
      for (int i = 0; i < MAX_STATIONS; i++) neighbor_rows[i] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_lone_station();
      test_distance_boundary();
      test_far_corners();
      test_stacked_cluster();
      test_store_full();
      test_random_batches(100);
      drain_results();

      if (mismatch_count == 0) begin
         $display("interference_graph_greedy_coloring_top: match");
      end else begin
         $display("interference_graph_greedy_coloring_top: mismatch");
      end
      $finish;
   end

endmodule
